### rtl/core/salc_pkg.sv
// salc_pkg: shared types and constants for the set-associative lru cache lookup
// used by salc_index, salc_scan, salc_store and the top level
package salc_pkg;

   localparam int TOTAL_LINES = 256;
   localparam int MAX_WAYS    = 8;
   localparam int ADDR_BITS = 32;
   localparam int CNT_BITS  = 32;
   localparam int WAY_BITS  = 3;
   localparam int WAY_SLOTS = 1 << WAY_BITS;
   localparam int RANK_BITS = 3;
   localparam int WCNT_BITS = 4;
   localparam int LOG2W_BITS = 2;

   localparam int CSR_DATA_BITS = 32;
   localparam int CSR_ADDR_BITS = 3;
   localparam logic [CSR_ADDR_BITS-3:0] REG_LOG2_WAYS = '0;
   localparam logic [LOG2W_BITS-1:0] LOG2_WAYS_RESET = 2'd2;

   typedef struct packed {
      logic                 valid;
      logic [RANK_BITS-1:0] rank;
   } meta_type;

   typedef struct packed {
      logic                clear;
      logic                load;
      logic [WAY_BITS-1:0] way;
   } scan_ctl_type;

   typedef struct packed {
      logic                 hit;
      logic                 ev_valid;
      logic [WAY_BITS-1:0]  victim;
      logic [ADDR_BITS-1:0] ev_addr;
   } scan_res_type;

endpackage

### rtl/core/salc_index.sv
// salc_index: turns an address into the first line index of its set
// depends on salc_pkg; set counts are powers of two, so the remainder is a mask
module salc_index
   import salc_pkg::*;
(
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [ADDR_BITS-1:0]           address,
   input  logic [LOG2W_BITS-1:0]          log2_ways,
   input  logic [WCNT_BITS-1:0]           ways,
   output logic                           done,
   output logic [$clog2(TOTAL_LINES)-1:0] base
);

   localparam int LINE_BITS = $clog2(TOTAL_LINES);
   localparam int SET_BITS  = $clog2(TOTAL_LINES + 1);

   localparam int W_0 = (MAX_WAYS < 1) ? MAX_WAYS : 1;
   localparam int W_1 = (MAX_WAYS < 2) ? MAX_WAYS : 2;
   localparam int W_2 = (MAX_WAYS < 4) ? MAX_WAYS : 4;
   localparam int W_3 = (MAX_WAYS < 8) ? MAX_WAYS : 8;
   localparam int SETS_0 = TOTAL_LINES / W_0;
   localparam int SETS_1 = TOTAL_LINES / W_1;
   localparam int SETS_2 = TOTAL_LINES / W_2;
   localparam int SETS_3 = TOTAL_LINES / W_3;

   logic [SET_BITS-1:0]  sets;
   logic [LINE_BITS-1:0] masked;

   logic                 done_ff, done_in;
   logic [LINE_BITS-1:0] base_ff, base_in;

   always_comb begin
      case (log2_ways)
         2'd0: begin
            sets = SET_BITS'(SETS_0);
         end
         2'd1: begin
            sets = SET_BITS'(SETS_1);
         end
         2'd2: begin
            sets = SET_BITS'(SETS_2);
         end
         default: begin
            sets = SET_BITS'(SETS_3);
         end
      endcase
   end

   assign masked = address[LINE_BITS-1:0] & LINE_BITS'(sets - SET_BITS'(1));

   always_comb begin
      done_in = start;
      base_in = base_ff;
      if (start) begin
         base_in = LINE_BITS'(masked * ways);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff <= 1'b0;
      end else begin
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      base_ff <= base_in;
   end

   assign done = done_ff;
   assign base = base_ff;

endmodule

### rtl/core/salc_scan.sv
// salc_scan: shared way unit; compares one way per cycle while a set is read,
// then yields the new recency of one way per cycle for the write-back. depends on salc_pkg
module salc_scan
   import salc_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  scan_ctl_type         ctl,
   input  meta_type             rd_meta,
   input  logic [ADDR_BITS-1:0] rd_tag,
   input  logic [ADDR_BITS-1:0] address,
   input  logic [RANK_BITS-1:0] top_rank,
   input  logic [WAY_BITS-1:0]  wr_way,
   output meta_type             wr_meta,
   output scan_res_type         res
);

   meta_type             snap_ff [WAY_SLOTS];
   logic                 hit_ff, hit_in;
   logic [WAY_BITS-1:0]  hit_way_ff, hit_way_in;
   logic [RANK_BITS-1:0] old_rank_ff, old_rank_in;
   logic                 empty_ff, empty_in;
   logic [WAY_BITS-1:0]  empty_way_ff, empty_way_in;
   logic [RANK_BITS-1:0] best_rank_ff, best_rank_in;
   logic [WAY_BITS-1:0]  best_way_ff, best_way_in;
   logic [ADDR_BITS-1:0] best_tag_ff, best_tag_in;

   meta_type             cur;
   logic [WAY_BITS-1:0]  victim;
   logic                 full;

   always_comb begin
      hit_in       = hit_ff;
      hit_way_in   = hit_way_ff;
      old_rank_in  = old_rank_ff;
      empty_in     = empty_ff;
      empty_way_in = empty_way_ff;
      best_rank_in = best_rank_ff;
      best_way_in  = best_way_ff;
      best_tag_in  = best_tag_ff;
      if (ctl.clear) begin
         hit_in   = 1'b0;
         empty_in = 1'b0;
      end else if (ctl.load) begin
         if (rd_meta.valid) begin
            if (!hit_ff && rd_tag == address) begin
               hit_in      = 1'b1;
               hit_way_in  = ctl.way;
               old_rank_in = rd_meta.rank;
            end
         end else if (!empty_ff) begin
            empty_in     = 1'b1;
            empty_way_in = ctl.way;
         end
         // lowest way among the largest ranks wins
         if (ctl.way == '0 || rd_meta.rank > best_rank_ff) begin
            best_rank_in = rd_meta.rank;
            best_way_in  = ctl.way;
            best_tag_in  = rd_tag;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_ff   <= 1'b0;
         empty_ff <= 1'b0;
      end else begin
         hit_ff   <= hit_in;
         empty_ff <= empty_in;
      end
   end

   always_ff @(posedge clock) begin
      hit_way_ff   <= hit_way_in;
      old_rank_ff  <= old_rank_in;
      empty_way_ff <= empty_way_in;
      best_rank_ff <= best_rank_in;
      best_way_ff  <= best_way_in;
      best_tag_ff  <= best_tag_in;
      if (ctl.load) begin
         snap_ff[ctl.way] <= rd_meta;
      end
   end

   assign full   = !hit_ff && !empty_ff;
   assign victim = hit_ff ? hit_way_ff : (empty_ff ? empty_way_ff : best_way_ff);

   assign res.hit      = hit_ff;
   assign res.ev_valid = full;
   assign res.victim   = victim;
   assign res.ev_addr  = full ? best_tag_ff : '0;

   // recency update for the way being written back
   always_comb begin
      cur     = snap_ff[wr_way];
      wr_meta = cur;
      if (wr_way == victim) begin
         wr_meta.valid = 1'b1;
         wr_meta.rank  = '0;
      end else if (cur.valid && cur.rank < top_rank) begin
         if (!hit_ff || cur.rank < old_rank_ff) begin
            wr_meta.rank = cur.rank + RANK_BITS'(1);
         end
      end
   end

endmodule

### rtl/core/salc_store.sv
// salc_store: tag and recency memories, one read and one write port each,
// plus the clearing pass over the valid bits after reset. depends on salc_pkg
module salc_store
   import salc_pkg::*;
(
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           rd_en,
   input  logic [$clog2(TOTAL_LINES)-1:0] rd_addr,
   output meta_type                       rd_meta,
   output logic [ADDR_BITS-1:0]           rd_tag,
   input  logic                           meta_we,
   input  logic                           tag_we,
   input  logic [$clog2(TOTAL_LINES)-1:0] wr_addr,
   input  meta_type                       wr_meta,
   input  logic [ADDR_BITS-1:0]           wr_tag,
   output logic                           clearing
);

   localparam int LINE_BITS = $clog2(TOTAL_LINES);

   meta_type             meta_mem [TOTAL_LINES];
   logic [ADDR_BITS-1:0] tag_mem [TOTAL_LINES];
   meta_type             rd_meta_ff;
   logic [ADDR_BITS-1:0] rd_tag_ff;

   logic                 clr_busy_ff, clr_busy_in;
   logic [LINE_BITS-1:0] clr_idx_ff, clr_idx_in;

   logic                 m_we;
   logic [LINE_BITS-1:0] m_addr;
   meta_type             m_data;

   always_comb begin
      clr_busy_in = clr_busy_ff;
      clr_idx_in  = clr_idx_ff;
      if (clr_busy_ff) begin
         clr_idx_in = clr_idx_ff + LINE_BITS'(1);
         if (clr_idx_ff == LINE_BITS'(TOTAL_LINES - 1)) begin
            clr_busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_idx_ff  <= '0;
      end else begin
         clr_busy_ff <= clr_busy_in;
         clr_idx_ff  <= clr_idx_in;
      end
   end

   assign m_we   = clr_busy_ff || meta_we;
   assign m_addr = clr_busy_ff ? clr_idx_ff : wr_addr;
   assign m_data = clr_busy_ff ? meta_type'('0) : wr_meta;

   always_ff @(posedge clock) begin
      if (m_we) begin
         meta_mem[m_addr] <= m_data;
      end
      if (rd_en) begin
         rd_meta_ff <= meta_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (tag_we) begin
         tag_mem[wr_addr] <= wr_tag;
      end
      if (rd_en) begin
         rd_tag_ff <= tag_mem[rd_addr];
      end
   end

   assign rd_meta  = rd_meta_ff;
   assign rd_tag   = rd_tag_ff;
   assign clearing = clr_busy_ff;

endmodule

### rtl/core/set_assoc_lru_cache_lookup_top.sv
// set_assoc_lru_cache_lookup_top: set-associative cache lookup, lru replacement
// sequence: index, ways reads, drain, ways write-backs, output load;
// the result waits while the output register is full
// one beat at a time: a new beat is accepted only in idle, after the last result is loaded
// reset: after reset the valid bits are cleared one line per cycle, over all TOTAL_LINES lines,
// with req_ready low; config and counters reset at once (log2_ways = 2)
module set_assoc_lru_cache_lookup_top
   import salc_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [ADDR_BITS-1:0]     req_address,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic                     rsp_hit,
   output logic [WAY_BITS-1:0]      rsp_way,
   output logic                     rsp_evicted_valid,
   output logic [ADDR_BITS-1:0]     rsp_evicted_address,
   output logic [CNT_BITS-1:0]      rsp_hit_total,
   output logic [CNT_BITS-1:0]      rsp_access_total,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [CSR_DATA_BITS-1:0] csr_prdata,
   output logic                     csr_pready
);

   localparam int LINE_BITS = $clog2(TOTAL_LINES);
   localparam logic [WCNT_BITS-1:0] WAYS_CAP =
      WCNT_BITS'((MAX_WAYS > WAY_SLOTS) ? WAY_SLOTS : MAX_WAYS);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_INDEX = 3'd1;
   localparam logic [2:0] ST_READ  = 3'd2;
   localparam logic [2:0] ST_DRAIN = 3'd3;
   localparam logic [2:0] ST_WRITE = 3'd4;
   localparam logic [2:0] ST_DONE  = 3'd5;

   logic [2:0]            state_ff, state_in;
   logic [WAY_BITS-1:0]   rd_way_ff, rd_way_in;
   logic [WAY_BITS-1:0]   wr_way_ff, wr_way_in;
   logic                  ld_valid_ff, ld_valid_in;
   logic [WAY_BITS-1:0]   ld_way_ff;
   logic [ADDR_BITS-1:0]  addr_ff;
   logic [LOG2W_BITS-1:0] log2_ways_ff;
   logic [CNT_BITS-1:0]   hits_ff, hits_in;
   logic [CNT_BITS-1:0]   accs_ff, accs_in;

   logic                  rsp_valid_ff;
   logic                  rsp_hit_ff;
   logic [WAY_BITS-1:0]   rsp_way_ff;
   logic                  rsp_ev_valid_ff;
   logic [ADDR_BITS-1:0]  rsp_ev_addr_ff;
   logic [CNT_BITS-1:0]   rsp_hits_ff;
   logic [CNT_BITS-1:0]   rsp_accs_ff;

   logic                  req_accept;
   logic                  csr_wr;
   logic [WCNT_BITS-1:0]  ways_full;
   logic [WCNT_BITS-1:0]  ways;
   logic [WAY_BITS-1:0]   last_way;
   logic [RANK_BITS-1:0]  top_rank;
   logic                  idx_done;
   logic [LINE_BITS-1:0]  base;
   logic                  clearing;
   logic                  rd_en;
   logic                  meta_we;
   logic                  tag_we;
   logic                  out_load;
   meta_type              rd_meta;
   logic [ADDR_BITS-1:0]  rd_tag;
   meta_type              wr_meta;
   scan_ctl_type          scan_ctl;
   scan_res_type          res;

   assign ways_full = WCNT_BITS'(1) << log2_ways_ff;
   assign ways      = (ways_full > WAYS_CAP) ? WAYS_CAP : ways_full;
   assign last_way  = WAY_BITS'(ways - WCNT_BITS'(1));
   assign top_rank  = RANK_BITS'(ways - WCNT_BITS'(1));

   assign req_ready  = (state_ff == ST_IDLE) && !clearing;
   assign req_accept = req_valid && req_ready;

   // config port
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready &&
                       csr_paddr[CSR_ADDR_BITS-1:2] == REG_LOG2_WAYS;
   assign csr_prdata = (csr_paddr[CSR_ADDR_BITS-1:2] == REG_LOG2_WAYS) ?
                       CSR_DATA_BITS'(log2_ways_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         log2_ways_ff <= LOG2_WAYS_RESET;
      end else if (csr_wr) begin
         log2_ways_ff <= csr_pwdata[LOG2W_BITS-1:0];
      end
   end

   // sequencer
   always_comb begin
      state_in    = state_ff;
      rd_way_in   = rd_way_ff;
      wr_way_in   = wr_way_ff;
      ld_valid_in = 1'b0;
      rd_en       = 1'b0;
      meta_we     = 1'b0;
      tag_we      = 1'b0;
      out_load    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               state_in = ST_INDEX;
            end
         end
         ST_INDEX: begin
            if (idx_done) begin
               state_in  = ST_READ;
               rd_way_in = '0;
            end
         end
         ST_READ: begin
            rd_en       = 1'b1;
            ld_valid_in = 1'b1;
            if (rd_way_ff == last_way) begin
               state_in = ST_DRAIN;
            end else begin
               rd_way_in = rd_way_ff + WAY_BITS'(1);
            end
         end
         ST_DRAIN: begin
            state_in  = ST_WRITE;
            wr_way_in = '0;
         end
         ST_WRITE: begin
            meta_we = 1'b1;
            tag_we  = !res.hit && wr_way_ff == res.victim;
            if (wr_way_ff == last_way) begin
               state_in = ST_DONE;
            end else begin
               wr_way_in = wr_way_ff + WAY_BITS'(1);
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               out_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // saturating running counts
   always_comb begin
      hits_in = hits_ff;
      accs_in = accs_ff;
      if (out_load) begin
         if (accs_ff != '1) begin
            accs_in = accs_ff + CNT_BITS'(1);
         end
         if (res.hit && hits_ff != '1) begin
            hits_in = hits_ff + CNT_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ld_valid_ff  <= 1'b0;
         hits_ff      <= '0;
         accs_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         ld_valid_ff <= ld_valid_in;
         hits_ff     <= hits_in;
         accs_ff     <= accs_in;
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      rd_way_ff <= rd_way_in;
      wr_way_ff <= wr_way_in;
      ld_way_ff <= rd_way_ff;
      if (req_accept) begin
         addr_ff <= req_address;
      end
      if (out_load) begin
         rsp_hit_ff      <= res.hit;
         rsp_way_ff      <= res.victim;
         rsp_ev_valid_ff <= res.ev_valid;
         rsp_ev_addr_ff  <= res.ev_addr;
         rsp_hits_ff     <= hits_in;
         rsp_accs_ff     <= accs_in;
      end
   end

   assign scan_ctl.clear = req_accept;
   assign scan_ctl.load  = ld_valid_ff;
   assign scan_ctl.way   = ld_way_ff;

   salc_index u_index (
      .clock     (clock),
      .reset     (reset),
      .start     (req_accept),
      .address   (req_address),
      .log2_ways (log2_ways_ff),
      .ways      (ways),
      .done      (idx_done),
      .base      (base)
   );

   salc_store u_store (
      .clock    (clock),
      .reset    (reset),
      .rd_en    (rd_en),
      .rd_addr  (base + LINE_BITS'(rd_way_ff)),
      .rd_meta  (rd_meta),
      .rd_tag   (rd_tag),
      .meta_we  (meta_we),
      .tag_we   (tag_we),
      .wr_addr  (base + LINE_BITS'(wr_way_ff)),
      .wr_meta  (wr_meta),
      .wr_tag   (addr_ff),
      .clearing (clearing)
   );

   salc_scan u_scan (
      .clock    (clock),
      .reset    (reset),
      .ctl      (scan_ctl),
      .rd_meta  (rd_meta),
      .rd_tag   (rd_tag),
      .address  (addr_ff),
      .top_rank (top_rank),
      .wr_way   (wr_way_ff),
      .wr_meta  (wr_meta),
      .res      (res)
   );

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_hit             = rsp_hit_ff;
   assign rsp_way             = rsp_way_ff;
   assign rsp_evicted_valid   = rsp_ev_valid_ff;
   assign rsp_evicted_address = rsp_ev_addr_ff;
   assign rsp_hit_total       = rsp_hits_ff;
   assign rsp_access_total    = rsp_accs_ff;

endmodule
